// ----- hdl/xdst_pkg.sv -----
// xdst_pkg: shared constants and types for xor_delta_state_table.
// Register offsets, command codes and table geometry. No dependencies.
package xdst_pkg;

	// Base-state table geometry: an 8-bit index addresses all entries directly
	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned IDX_W       = 8;
	localparam int unsigned STATE_W     = 64;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned OFF_W       = 6;

	// Configuration port: register 0 (layout select) at byte 0
	localparam int unsigned PADDR_W     = 3;
	localparam logic        REG_LAYOUT  = 1'b0;

	localparam logic LAYOUT_CSR = 1'b0;
	localparam logic LAYOUT_CMD = 1'b1;

	// Direct CSR layout offsets
	localparam logic [OFF_W-1:0] CSR_PEND_IDX  = 6'h00;
	localparam logic [OFF_W-1:0] CSR_LOAD_LO   = 6'h04;
	localparam logic [OFF_W-1:0] CSR_LOAD_HI   = 6'h08;
	localparam logic [OFF_W-1:0] CSR_ACCUM_LO  = 6'h0C;
	localparam logic [OFF_W-1:0] CSR_ACCUM_HI  = 6'h10;
	localparam logic [OFF_W-1:0] CSR_SWAP      = 6'h14;
	localparam logic [OFF_W-1:0] CSR_CONFIG    = 6'h18;
	localparam logic [OFF_W-1:0] CSR_SNAP_LO   = 6'h1C;
	localparam logic [OFF_W-1:0] CSR_SNAP_HI   = 6'h20;
	localparam logic [OFF_W-1:0] CSR_STATUS    = 6'h24;

	// Command layout offsets
	localparam logic [OFF_W-1:0] CMD_EXEC      = 6'h00;
	localparam logic [OFF_W-1:0] CMD_RS1       = 6'h04;
	localparam logic [OFF_W-1:0] CMD_RS2       = 6'h08;
	localparam logic [OFF_W-1:0] CMD_RD        = 6'h0C;
	localparam logic [OFF_W-1:0] CMD_ID        = 6'h10;

	localparam logic [WORD_W-1:0] CMD_ID_VALUE = 32'h0000_0002;
	localparam logic [WORD_W-1:0] STATUS_BASE  = (32'h02 << 16) | (32'h01 << 8);

	// funct3 codes of the command register
	typedef enum logic [2:0] {
		FN_SELECT   = 3'd0,
		FN_DELTA_LO = 3'd1,
		FN_READ_LO  = 3'd2,
		FN_MOVE     = 3'd3,
		FN_LOAD     = 3'd4,
		FN_ACCUM    = 3'd5,
		FN_READ_HI  = 3'd6,
		FN_STATUS   = 3'd7
	} funct_t;

endpackage

// ----- hdl/xor_delta_state_table.sv -----
// xor_delta_state_table: register-mapped XOR delta-state engine, top level.
// Depends on xdst_pkg for offsets, command codes and widths.
//
// Usage:
//  - Request channel (in_valid/in_stall): one bus access per transaction,
//    cmd (0 read, 1 write), word-aligned offset and write_data.
//  - Response channel (out_valid/out_stall): exactly one read_data per
//    request transaction, in order; zero for writes and unmapped offsets.
//  - APB port: register 0 (layout_select) at byte 0. Layout 0 is the direct
//    CSR map, layout 1 the rs1/rs2/rd command map. Write it only while idle.
//  - Pipeline: a request accepted is held in the input stage, which holds
//    the table read, then in the output register, which holds the word.
//  - Throughput: one transaction per cycle when out_stall stays low. Each
//    access does at most one table read (issued as the request is taken)
//    and one table write (on leaving input stage); a prior write is forwarded.
//  - Stall: when out_stall holds a waiting response, the input stage keeps
//    its transaction and in_stall rises only if that stage is occupied.
//  - Reset: asynchronous, arst_n low. Accumulator, indices, latches and
//    operands clear, enable is set, layout goes to 0. The table itself is
//    not swept: per-entry valid bits clear at once and an entry never
//    written reads as zero, so requests are taken right after reset.
module xor_delta_state_table (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [xdst_pkg::PADDR_W-1:0]        paddr,
	input  logic [xdst_pkg::WORD_W-1:0]         pwdata,
	output logic [xdst_pkg::WORD_W-1:0]         prdata,
	output logic                                pready,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [xdst_pkg::OFF_W-1:0]          offset,
	input  logic [xdst_pkg::WORD_W-1:0]         write_data,
	// response channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [xdst_pkg::WORD_W-1:0]         read_data
);

	localparam int unsigned IW = xdst_pkg::IDX_W;
	localparam int unsigned SW = xdst_pkg::STATE_W;
	localparam int unsigned WW = xdst_pkg::WORD_W;
	localparam int unsigned OW = xdst_pkg::OFF_W;

	// ---------------- configuration ----------------
	logic layout_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[xdst_pkg::PADDR_W-1] == xdst_pkg::REG_LAYOUT) ?
		{{(WW-1){1'b0}}, layout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= xdst_pkg::LAYOUT_CSR;
		end else if (cfg_wr && (paddr[xdst_pkg::PADDR_W-1] == xdst_pkg::REG_LAYOUT)) begin
			layout_q <= pwdata[0];
		end
	end

	// ---------------- handshake ----------------
	logic          s1_valid;
	logic          s1_cmd;
	logic [OW-1:0] s1_off;
	logic [WW-1:0] s1_data;
	logic          out_valid_q;
	logic [WW-1:0] read_data_q;
	logic          advance;
	logic          in_acc;
	logic          commit;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid && !advance;
	assign in_acc    = in_valid && !in_stall;
	assign commit    = s1_valid && advance;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// ---------------- architectural state ----------------
	logic [SW-1:0] accum_q,     accum_d;
	logic [IW-1:0] act_idx_q,   act_idx_d;
	logic [SW-1:0] act_base_q,  act_base_d;   // copy of table[act_idx_q]
	logic [SW-1:0] snap_q,      snap_d;
	logic [IW-1:0] pend_idx_q,  pend_idx_d;
	logic [WW-1:0] load_lo_q,   load_lo_d;
	logic [WW-1:0] acc_lo_q,    acc_lo_d;
	logic          enable_q,    enable_d;
	logic [WW-1:0] op1_q,       op1_d;
	logic [WW-1:0] op2_q,       op2_d;
	logic [WW-1:0] res_q,       res_d;
	logic [WW-1:0] cload_lo_q,  cload_lo_d;
	logic [WW-1:0] cdelta_lo_q, cdelta_lo_d;

	// ---------------- table ----------------
	logic [SW-1:0] mem [xdst_pkg::TABLE_DEPTH];
	logic [xdst_pkg::TABLE_DEPTH-1:0] ent_vld_q;
	logic [SW-1:0] mem_rd_s1;
	logic          vld_rd_s1;
	logic          fwd_s1;
	logic [SW-1:0] fwd_data_s1;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [SW-1:0] wr_data;
	logic [SW-1:0] tbl_val;

	// Read address for the incoming access: swap target in CSR layout,
	// rs1 index (as it stands after the access ahead commits) in command layout.
	assign rd_addr = (layout_q == xdst_pkg::LAYOUT_CMD) ? op1_d[IW-1:0] : write_data[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (in_acc) begin
			mem_rd_s1   <= mem[rd_addr];
			vld_rd_s1   <= ent_vld_q[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr_en) begin
			ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Entry value at the read address, with write-through from the previous access
	assign tbl_val = fwd_s1 ? fwd_data_s1 : (vld_rd_s1 ? mem_rd_s1 : '0);

	// ---------------- access execution ----------------
	logic [SW-1:0]    cur;
	logic [SW-1:0]    moved;
	logic [WW-1:0]    status;
	logic [WW-1:0]    rd_val;
	xdst_pkg::funct_t fn;

	assign cur    = act_base_q ^ accum_q;
	assign status = xdst_pkg::STATUS_BASE | {{(WW-1){1'b0}}, (accum_q == '0)};
	assign fn     = xdst_pkg::funct_t'(s1_data[2:0]);
	assign moved  = tbl_val ^ accum_q;

	always_comb begin
		accum_d     = accum_q;
		act_idx_d   = act_idx_q;
		act_base_d  = act_base_q;
		snap_d      = snap_q;
		pend_idx_d  = pend_idx_q;
		load_lo_d   = load_lo_q;
		acc_lo_d    = acc_lo_q;
		enable_d    = enable_q;
		op1_d       = op1_q;
		op2_d       = op2_q;
		res_d       = res_q;
		cload_lo_d  = cload_lo_q;
		cdelta_lo_d = cdelta_lo_q;
		wr_en       = 1'b0;
		wr_addr     = act_idx_q;
		wr_data     = cur;
		rd_val      = '0;

		if (commit) begin
			if (layout_q == xdst_pkg::LAYOUT_CSR) begin
				if (s1_cmd) begin
					case (s1_off)
						xdst_pkg::CSR_PEND_IDX: pend_idx_d = s1_data[IW-1:0];
						xdst_pkg::CSR_LOAD_LO:  load_lo_d  = s1_data;
						xdst_pkg::CSR_LOAD_HI: begin
							act_idx_d  = pend_idx_q;
							wr_en      = 1'b1;
							wr_addr    = pend_idx_q;
							wr_data    = {s1_data, load_lo_q};
							act_base_d = {s1_data, load_lo_q};
							accum_d    = '0;
						end
						xdst_pkg::CSR_ACCUM_LO: acc_lo_d = s1_data;
						xdst_pkg::CSR_ACCUM_HI: accum_d  = accum_q ^ {s1_data, acc_lo_q};
						xdst_pkg::CSR_SWAP: begin
							// old entry takes the live state, then move to the new index
							wr_en      = 1'b1;
							wr_addr    = act_idx_q;
							wr_data    = cur;
							accum_d    = '0;
							act_idx_d  = s1_data[IW-1:0];
							act_base_d = (s1_data[IW-1:0] == act_idx_q) ? cur : tbl_val;
						end
						xdst_pkg::CSR_CONFIG: begin
							enable_d = s1_data[0];
							if (!s1_data[0]) begin
								accum_d = '0;
							end
						end
						default: ;
					endcase
				end else begin
					case (s1_off)
						xdst_pkg::CSR_SNAP_LO: begin
							snap_d = cur;
							rd_val = cur[WW-1:0];
						end
						xdst_pkg::CSR_SNAP_HI: rd_val = snap_q[SW-1:WW];
						xdst_pkg::CSR_STATUS:  rd_val = status;
						xdst_pkg::CSR_CONFIG:  rd_val = {{(WW-1){1'b0}}, enable_q};
						default:               rd_val = '0;
					endcase
				end
			end else begin
				if (s1_cmd) begin
					case (s1_off)
						xdst_pkg::CMD_EXEC: begin
							case (fn)
								xdst_pkg::FN_SELECT: begin
									act_idx_d  = op1_q[IW-1:0];
									act_base_d = tbl_val;
									cload_lo_d = op2_q;
								end
								xdst_pkg::FN_LOAD: begin
									wr_en      = 1'b1;
									wr_addr    = act_idx_q;
									wr_data    = {op2_q, cload_lo_q};
									act_base_d = {op2_q, cload_lo_q};
									accum_d    = '0;
								end
								xdst_pkg::FN_DELTA_LO: cdelta_lo_d = op1_q;
								xdst_pkg::FN_ACCUM:    accum_d = accum_q ^ {op1_q, cdelta_lo_q};
								xdst_pkg::FN_READ_LO:  res_d = cur[WW-1:0];
								xdst_pkg::FN_READ_HI:  res_d = cur[SW-1:WW];
								xdst_pkg::FN_MOVE: begin
									// index moves first; the new entry absorbs the delta
									act_idx_d  = op1_q[IW-1:0];
									wr_en      = 1'b1;
									wr_addr    = op1_q[IW-1:0];
									wr_data    = moved;
									act_base_d = moved;
									accum_d    = '0;
								end
								default: res_d = status;
							endcase
						end
						xdst_pkg::CMD_RS1: op1_d = s1_data;
						xdst_pkg::CMD_RS2: op2_d = s1_data;
						default: ;
					endcase
				end else begin
					case (s1_off)
						xdst_pkg::CMD_RD:  rd_val = res_q;
						xdst_pkg::CMD_ID:  rd_val = xdst_pkg::CMD_ID_VALUE;
						xdst_pkg::CMD_RS1: rd_val = op1_q;
						xdst_pkg::CMD_RS2: rd_val = op2_q;
						default:           rd_val = '0;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			act_idx_q   <= '0;
			act_base_q  <= '0;
			snap_q      <= '0;
			pend_idx_q  <= '0;
			load_lo_q   <= '0;
			acc_lo_q    <= '0;
			enable_q    <= 1'b1;
			op1_q       <= '0;
			op2_q       <= '0;
			res_q       <= '0;
			cload_lo_q  <= '0;
			cdelta_lo_q <= '0;
		end else begin
			accum_q     <= accum_d;
			act_idx_q   <= act_idx_d;
			act_base_q  <= act_base_d;
			snap_q      <= snap_d;
			pend_idx_q  <= pend_idx_d;
			load_lo_q   <= load_lo_d;
			acc_lo_q    <= acc_lo_d;
			enable_q    <= enable_d;
			op1_q       <= op1_d;
			op2_q       <= op2_d;
			res_q       <= res_d;
			cload_lo_q  <= cload_lo_d;
			cdelta_lo_q <= cdelta_lo_d;
		end
	end

	// ---------------- pipeline control ----------------
	// An empty input stage takes a request even while the output waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= s1_valid;
			end
			s1_valid <= in_acc || (s1_valid && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_cmd  <= cmd;
			s1_off  <= offset;
			s1_data <= write_data;
		end
		if (commit) begin
			read_data_q <= rd_val;
		end
	end

endmodule
